>>> design/assert_macros.svh
// Assertion macros shared by the min-tracking stack RTL.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check a same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/mtstk_pkg.sv
// Package for the min-tracking stack: widths, operation and status codes,
// entry and RAM control types. No dependencies.
`default_nettype none

package mtstk_pkg;

   localparam int DATA_W        = 32;
   localparam int FILL_W        = 8;
   localparam int DEPTH_DEFAULT = 128;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] minimum;
   } mtstk_entry_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mtstk_ram_ctl_type;

endpackage

`default_nettype wire

>>> design/mtstk_if.sv
// Handshake interfaces for the request and response channels of the stack.
// Depends on mtstk_pkg for field widths.
`default_nettype none

interface mtstk_req_if;
   import mtstk_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic signed [DATA_W-1:0] push_value;

   modport source (output valid, output kind, output push_value, input ready);
   modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface mtstk_rsp_if;
   import mtstk_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] top_value;
   logic signed [DATA_W-1:0] min_value;
   logic                     is_empty;
   logic [FILL_W-1:0]        fill_count;
   logic [1:0]               status;

   modport source (output valid, output top_value, output min_value, output is_empty,
                   output fill_count, output status, input ready);
   modport sink   (input valid, input top_value, input min_value, input is_empty,
                   input fill_count, input status, output ready);
endinterface

`default_nettype wire

>>> design/min_tracking_stack_unit.sv
// Top level of the min-tracking stack: top-of-stack registers, control and
// response register. Depends on mtstk_pkg, mtstk_if, mtstk_entry_ram and assert_macros.svh.
`default_nettype none

//  channel   | direction | payload
//  ----------+-----------+--------------------------------------------------
//  req_chan  | in        | kind, push_value
//  rsp_chan  | out       | top_value, min_value, is_empty, fill_count, status
//
//  A push, a rejected item, or a pop that leaves the stack empty loads the response
//  register on acceptance. A pop that leaves one or more entries first enters the
//  pop-wait state and reads the new top from the entry RAM (registered read data).
//  Reset clears the entry count, the pop-wait state and the response valid;
//  RAM contents need no clearing pass.
//  A request transfers when no pop read is pending and no response is held or the held
//  one transfers in the same cycle; a stalled response blocks further requests.
module min_tracking_stack_unit #(
   parameter int DEPTH = mtstk_pkg::DEPTH_DEFAULT
) (
   input wire          clock,
   input wire          reset,
   mtstk_req_if.sink   req_chan,
   mtstk_rsp_if.source rsp_chan
);
   import mtstk_pkg::*;

`include "assert_macros.svh"

   // The top entry lives in registers; the RAM holds only the entries below it.
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int RAM_DEPTH = DEPTH - 1;
   localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   localparam logic ST_IDLE     = 1'b0;
   localparam logic ST_POP_WAIT = 1'b1;

   logic                     state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [DATA_W-1:0] top_value_ff, top_value_in;
   logic signed [DATA_W-1:0] top_min_ff, top_min_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_top_ff, rsp_top_in;
   logic signed [DATA_W-1:0] rsp_min_ff, rsp_min_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   logic [FILL_W-1:0]        rsp_fill_ff, rsp_fill_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;

   logic                     req_ready;
   logic                     req_accept;
   logic                     load_rsp;
   logic [1:0]               res_status;
   logic [CNT_W+FILL_W-1:0]  count_wide;

   mtstk_ram_ctl_type        ram_ctl;
   logic [ADDR_W-1:0]        wr_addr;
   logic [ADDR_W-1:0]        rd_addr;
   mtstk_entry_type          wr_data;
   mtstk_entry_type          rd_data;

   mtstk_entry_ram #(
      .RAM_DEPTH (RAM_DEPTH),
      .ADDR_W    (ADDR_W)
   ) u_entry_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Take a request only while idle and the response slot is free or draining.
   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept = req_chan.valid && req_ready;

   // A push spills the old top to index count-1; a pop reloads index count-2.
   // Reads and writes never fall in the same cycle, so no forwarding is needed.
   assign wr_addr = ADDR_W'(count_ff - CNT_W'(1));
   assign rd_addr = ADDR_W'(count_ff - CNT_W'(2));
   assign wr_data = '{value: top_value_ff, minimum: top_min_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      top_value_in = top_value_ff;
      top_min_in   = top_min_ff;
      ram_ctl      = '0;
      res_status   = STATUS_OK;
      load_rsp     = 1'b0;

      if (state_ff == ST_POP_WAIT) begin
         // Install the entry read back from the RAM as the new top.
         top_value_in = rd_data.value;
         top_min_in   = rd_data.minimum;
         state_in     = ST_IDLE;
         load_rsp     = 1'b1;
      end else if (req_accept) begin
         load_rsp = 1'b1;
         if (req_chan.kind == KIND_PUSH) begin
            if (count_ff == CNT_W'(DEPTH)) begin
               res_status = STATUS_FULL;
            end else begin
               ram_ctl.wr_en = (count_ff != '0);
               top_value_in  = req_chan.push_value;
               // Equal values keep the minimum from below.
               if ((count_ff == '0) || (req_chan.push_value < top_min_ff)) begin
                  top_min_in = req_chan.push_value;
               end else begin
                  top_min_in = top_min_ff;
               end
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if (count_ff == '0) begin
               res_status = STATUS_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff >= CNT_W'(2)) begin
                  // Fetch the entry below; the response waits for the read.
                  ram_ctl.rd_en = 1'b1;
                  state_in      = ST_POP_WAIT;
                  load_rsp      = 1'b0;
               end
            end
         end
      end
   end

   // Build the response from the state after the operation; empty reads as zero.
   assign count_wide = {{FILL_W{1'b0}}, count_in};

   always_comb begin
      rsp_top_in    = (count_in == '0) ? '0 : top_value_in;
      rsp_min_in    = (count_in == '0) ? '0 : top_min_in;
      rsp_empty_in  = (count_in == '0);
      rsp_fill_in   = count_wide[FILL_W-1:0];
      rsp_status_in = res_status;
      rsp_valid_in  = load_rsp || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold top registers and response payload; no reset needed.
   always_ff @(posedge clock) begin
      top_value_ff <= top_value_in;
      top_min_ff   <= top_min_in;
      if (load_rsp) begin
         rsp_top_ff    <= rsp_top_in;
         rsp_min_ff    <= rsp_min_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_fill_ff   <= rsp_fill_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.top_value  = rsp_top_ff;
   assign rsp_chan.min_value  = rsp_min_ff;
   assign rsp_chan.is_empty   = rsp_empty_ff;
   assign rsp_chan.fill_count = rsp_fill_ff;
   assign rsp_chan.status     = rsp_status_ff;

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH), "entry count above depth")
   `ASSERT_ALWAYS(a_ram_one_port, !(ram_ctl.wr_en && ram_ctl.rd_en),
      "RAM read and write overlap")
   `ASSERT_IMPLIES(a_wait_slot_free, state_ff == ST_POP_WAIT, !rsp_valid_ff,
      "response slot busy during pop read")
   `ASSERT_NEXT(a_wait_one_cycle, state_ff == ST_POP_WAIT, state_ff == ST_IDLE,
      "pop read wait exceeded one cycle")
   `ASSERT_NEXT(a_push_grows,
      req_accept && (req_chan.kind == KIND_PUSH) && (count_ff != CNT_W'(DEPTH)),
      count_ff == $past(count_ff) + CNT_W'(1), "accepted push did not grow stack")

endmodule

`default_nettype wire

>>> design/mtstk_entry_ram.sv
// Entry RAM for the stack: one write port, one read port, registered read data.
// Depends on mtstk_pkg for the entry and control types.
`default_nettype none

module mtstk_entry_ram #(
   parameter int RAM_DEPTH = 127,
   parameter int ADDR_W    = 7
) (
   input  wire                         clock,
   input  mtstk_pkg::mtstk_ram_ctl_type ctl,
   input  wire [ADDR_W-1:0]            wr_addr,
   input  mtstk_pkg::mtstk_entry_type  wr_data,
   input  wire [ADDR_W-1:0]            rd_addr,
   output mtstk_pkg::mtstk_entry_type  rd_data
);
   import mtstk_pkg::*;

   mtstk_entry_type mem [RAM_DEPTH];
   mtstk_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
